/* hw/rtl/roch_pkg.sv */
package roch_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LEN,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_SLAB,
    ST_SL1,
    ST_SL2,
    ST_UPD,
    ST_FIN,
    ST_OUT
  } st_t;

  // Multiplier schedule, one product per entry
  typedef enum logic [4:0] {
    OP_AX2,
    OP_AY2,
    OP_SF_U2,
    OP_SF_T1,
    OP_SF_T,
    OP_SF_R,
    OP_CF_U2,
    OP_CF_T1,
    OP_CF_T,
    OP_CF_R,
    OP_LOX_A,
    OP_LOX_B,
    OP_LOY_A,
    OP_LOY_B,
    OP_LDX_A,
    OP_LDX_B,
    OP_LDY_A,
    OP_LDY_B,
    OP_HX,
    OP_HY
  } op_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } sqrt_req_t;

  localparam logic [0:0]  REG_MASK = 1'b0;
  localparam logic [0:0]  REG_LEN  = 1'b1;

  localparam logic [14:0] TRIG_ONE = 15'd16384;
  localparam logic [14:0] SIN_A    = 15'd25736;
  localparam logic [13:0] SIN_B    = 14'd10512;
  localparam logic [10:0] SIN_C    = 11'd1160;
  localparam int          PAR_EPS  = 3;
  localparam logic [15:0] LEN_RST  = 16'd256;

endpackage

/* hw/rtl/roch_mul.sv */
module roch_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [27:0] a,
  input  logic signed [27:0] b,
  output logic signed [55:0] p
);

  logic signed [55:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/roch_div.sv */
module roch_div (
  input  logic               clk,
  input  logic               rst_n,
  input  roch_pkg::div_req_t req,
  output logic               done,
  output logic [63:0]        quot
);

  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[63]};
    diff     = rem_sh - {1'b0, dsr_r};
    ge       = rem_sh >= {1'b0, dsr_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : rem_sh[31:0];
      q_nxt   = {q_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* hw/rtl/roch_sqrt.sv */
module roch_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  roch_pkg::sqrt_req_t req,
  output logic                done,
  output logic [31:0]         root
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] b_r, b_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] rb;
  logic        ge;

  always_comb begin
    rb       = r_r + b_r;
    ge       = v_r >= rb;
    v_nxt    = v_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      v_nxt    = req.value;
      r_nxt    = '0;
      b_nxt    = 64'h4000_0000_0000_0000;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt   = ge ? v_r - rb : v_r;
      r_nxt   = ge ? (r_r >> 1) + b_r : r_r >> 1;
      b_nxt   = b_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r <= v_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

/* hw/rtl/ray_obb_closest_hit_top.sv */
// Nearest hit of a ray segment against a stream of oriented 2D boxes.
// Input channel: one request per box; it carries the ray origin and direction,
// the box, its group and skip flag, and in_tlast marks the final box of a query.
// Output channel: one result per query, sent after the last box: out_tuser is
// the hit flag, out_tdata the box ordinal, distance and hit point (all zero on
// a miss).
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0: group mask,
// 1: segment length, Q8.8). Write only while no query is in progress.
// Timing: one box at a time; in_tready is high only when the sequencer idles.
// A tested box runs a 28x28 multiplier through the schedule's products, a
// 32-step square root, and a bit-serial divider for up to six quotients per
// box (normalisation and two slabs); the divider takes most of the time.
// Skipped or masked boxes are not tested; the last box adds the hit point
// products, when a hit was found, and the result load.
// Reset clears the query state, mask 0 and segment length 1.0.
// The result is held in an output register; the next query proceeds while it
// waits, and only the following result stalls until out_tready takes it.
module ray_obb_closest_hit_top #(
  parameter int MAX_BOXES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ray_x, ray_y, dir_x, dir_y, box_x, box_y, box_w, box_h, box_angle, pad
  input  logic [207:0] in_tdata,
  // box_group, box_skip
  input  logic [4:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_index, hit_t, hit_px, hit_py
  output logic [71:0]  out_tdata,
  // hit
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_BOXES + 1);

  roch_pkg::st_t state_r, state_nxt;
  roch_pkg::op_t op_r, op_nxt;
  logic          half_r, half_nxt;
  logic          axis_r, axis_nxt;

  logic [3:0]  mask_r, mask_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [15:0] best_t_r, best_t_nxt;
  logic [7:0]  best_idx_r, best_idx_nxt;
  logic        found_r, found_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic signed [23:0] rx_r, ry_r, dx_r, dy_r, bx_r, by_r;
  logic signed [23:0] rx_nxt, ry_nxt, dx_nxt, dy_nxt, bx_nxt, by_nxt;
  logic [22:0] w_r, h_r, w_nxt, h_nxt;
  logic [15:0] ang_r, ang_nxt;
  logic        last_r, last_nxt, cand_r, cand_nxt;
  logic [7:0]  idx_r, idx_nxt;

  logic [47:0] len2_r, len2_nxt;
  logic [31:0] l_r, l_nxt;
  logic signed [15:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [14:0] u2_r, u2_nxt;
  logic [13:0] t1_r, t1_nxt;
  logic [14:0] tp_r, tp_nxt;
  logic [15:0] sf_r, cf_r, sf_nxt, cf_nxt;
  logic signed [47:0] acc_r, acc_nxt, lox_r, lox_nxt, loy_r, loy_nxt;
  logic signed [31:0] ldx_r, ldx_nxt, ldy_r, ldy_nxt;
  logic signed [63:0] tmin_r, tmin_nxt, tmax_r, tmax_nxt, tq_r, tq_nxt;
  logic        nsign_r, nsign_nxt;
  logic signed [23:0] px_r, py_r, px_nxt, py_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic [71:0] out_data_r, out_data_nxt;

  // Combinational datapath terms
  logic              accept;
  logic [CW+7:0]     cnt_ext;
  logic              in_cand;
  logic [23:0]       ax, ay;
  logic signed [26:0] relx, rely;
  logic signed [16:0] cv, sv;
  logic [14:0]       u;
  logic signed [55:0] pr;
  logic signed [47:0] o, hb;
  logic signed [31:0] d;
  logic [31:0]       dabs;
  logic              par, inr;
  logic signed [63:0] num, numabs, qs, lo, hi, tmin_c, tmax_c;
  logic              slab_ok;
  logic [15:0]       mcap;
  logic              load_out;

  logic               mul_en;
  logic signed [27:0] mul_a, mul_b;
  logic signed [55:0] prod;
  roch_pkg::div_req_t  div_req;
  roch_pkg::sqrt_req_t sqrt_req;
  logic               div_done, sqrt_done;
  logic [63:0]        quot;
  logic [31:0]        root;

  roch_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  roch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (quot)
  );

  roch_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .done  (sqrt_done),
    .root  (root)
  );

  function automatic logic signed [23:0] hit_coord(input logic signed [23:0] org,
                                                   input logic signed [55:0] p);
    logic [55:0]        mag;
    logic [55:0]        m;
    logic signed [25:0] r;
    begin
      mag = p[55] ? 56'(-p) : 56'(p);
      m   = (mag + 56'd8192) >> 14;
      r   = 26'(org) + (p[55] ? -$signed(26'(m)) : $signed(26'(m)));
      if (r > 26'sd8388607) begin
        hit_coord = 24'sd8388607;
      end else if (r < -26'sd8388608) begin
        hit_coord = -24'sd8388608;
      end else begin
        hit_coord = r[23:0];
      end
    end
  endfunction

  // Shared terms
  always_comb begin
    accept  = in_tvalid && in_tready;
    cnt_ext = {8'd0, cnt_r};
    in_cand = (cnt_r < CW'(MAX_BOXES)) && !in_tuser[4] && (in_tuser[3:0] == mask_r);
    ax      = dx_r[23] ? 24'(-dx_r) : 24'(dx_r);
    ay      = dy_r[23] ? 24'(-dy_r) : 24'(dy_r);
    relx    = (27'(rx_r) <<< 1) - (27'(bx_r) <<< 1) - $signed({4'd0, w_r});
    rely    = (27'(ry_r) <<< 1) - (27'(by_r) <<< 1) - $signed({4'd0, h_r});
    case (ang_r[15:14])
      2'd0: begin
        sv = $signed({1'b0, sf_r});
        cv = $signed({1'b0, cf_r});
      end
      2'd1: begin
        sv = $signed({1'b0, cf_r});
        cv = -$signed({1'b0, sf_r});
      end
      2'd2: begin
        sv = -$signed({1'b0, sf_r});
        cv = -$signed({1'b0, cf_r});
      end
      default: begin
        sv = -$signed({1'b0, cf_r});
        cv = $signed({1'b0, sf_r});
      end
    endcase
    u  = ((op_r == roch_pkg::OP_CF_U2) || (op_r == roch_pkg::OP_CF_R)) ?
         roch_pkg::TRIG_ONE - {1'b0, ang_r[13:0]} : {1'b0, ang_r[13:0]};
    pr = (prod + 56'sd8192) >>> 14;

    o    = axis_r ? loy_r : lox_r;
    d    = axis_r ? ldy_r : ldx_r;
    hb   = $signed(48'({(axis_r ? h_r : w_r), 14'd0}));
    dabs = d[31] ? 32'(-d) : 32'(d);
    par  = (d > -32'(roch_pkg::PAR_EPS)) && (d < 32'(roch_pkg::PAR_EPS));
    inr  = (o >= -hb) && (o <= hb);
    num  = (state_r == roch_pkg::ST_SLAB) ? (64'(-hb - o) <<< 13) : (64'(hb - o) <<< 13);
    numabs = num[63] ? -num : num;
    qs     = nsign_r ? -$signed(quot) : $signed(quot);
    lo     = (tq_r < qs) ? tq_r : qs;
    hi     = (tq_r < qs) ? qs : tq_r;
    tmin_c = (lo > tmin_r) ? lo : tmin_r;
    tmax_c = (hi < tmax_r) ? hi : tmax_r;
    slab_ok = tmin_c <= tmax_c;
    mcap    = (quot > 64'd16384) ? 16'd16384 : quot[15:0];
    load_out = (state_r == roch_pkg::ST_OUT) && (!out_valid_r || out_tready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      roch_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cand || in_tlast) ? roch_pkg::ST_MUL : roch_pkg::ST_FIN;
        end
      end
      roch_pkg::ST_MUL: begin
        if (half_r) begin
          case (op_r)
            roch_pkg::OP_AY2:  state_nxt = roch_pkg::ST_LEN;
            roch_pkg::OP_LDY_B: state_nxt = roch_pkg::ST_SLAB;
            roch_pkg::OP_HY:   state_nxt = roch_pkg::ST_OUT;
            default:           state_nxt = roch_pkg::ST_MUL;
          endcase
        end
      end
      roch_pkg::ST_LEN: begin
        state_nxt = (len2_r == '0) ? roch_pkg::ST_FIN : roch_pkg::ST_SQRT;
      end
      roch_pkg::ST_SQRT: begin
        if (sqrt_done) state_nxt = roch_pkg::ST_DIVX;
      end
      roch_pkg::ST_DIVX: begin
        if (div_done) state_nxt = roch_pkg::ST_DIVY;
      end
      roch_pkg::ST_DIVY: begin
        if (div_done) state_nxt = cand_r ? roch_pkg::ST_MUL : roch_pkg::ST_FIN;
      end
      roch_pkg::ST_SLAB: begin
        if (par) begin
          if (!inr) state_nxt = roch_pkg::ST_FIN;
          else      state_nxt = axis_r ? roch_pkg::ST_UPD : roch_pkg::ST_SLAB;
        end else begin
          state_nxt = roch_pkg::ST_SL1;
        end
      end
      roch_pkg::ST_SL1: begin
        if (div_done) state_nxt = roch_pkg::ST_SL2;
      end
      roch_pkg::ST_SL2: begin
        if (div_done) begin
          if (!slab_ok) state_nxt = roch_pkg::ST_FIN;
          else          state_nxt = axis_r ? roch_pkg::ST_UPD : roch_pkg::ST_SLAB;
        end
      end
      roch_pkg::ST_UPD: state_nxt = roch_pkg::ST_FIN;
      roch_pkg::ST_FIN: begin
        if (!last_r)      state_nxt = roch_pkg::ST_IDLE;
        else if (found_r) state_nxt = roch_pkg::ST_MUL;
        else              state_nxt = roch_pkg::ST_OUT;
      end
      roch_pkg::ST_OUT: begin
        if (load_out) state_nxt = roch_pkg::ST_IDLE;
      end
      default: state_nxt = roch_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, unit requests
  always_comb begin
    in_tready = (state_r == roch_pkg::ST_IDLE);
    mul_en    = (state_r == roch_pkg::ST_MUL) && !half_r;
    mul_a     = '0;
    mul_b     = '0;
    case (op_r)
      roch_pkg::OP_AX2: begin
        mul_a = 28'(ax);
        mul_b = 28'(ax);
      end
      roch_pkg::OP_AY2: begin
        mul_a = 28'(ay);
        mul_b = 28'(ay);
      end
      roch_pkg::OP_SF_U2, roch_pkg::OP_CF_U2: begin
        mul_a = 28'(u);
        mul_b = 28'(u);
      end
      roch_pkg::OP_SF_T1, roch_pkg::OP_CF_T1: begin
        mul_a = 28'(roch_pkg::SIN_C);
        mul_b = 28'(u2_r);
      end
      roch_pkg::OP_SF_T, roch_pkg::OP_CF_T: begin
        mul_a = 28'(u2_r);
        mul_b = 28'(t1_r);
      end
      roch_pkg::OP_SF_R, roch_pkg::OP_CF_R: begin
        mul_a = 28'(u);
        mul_b = 28'(tp_r);
      end
      roch_pkg::OP_LOX_A: begin
        mul_a = 28'(relx);
        mul_b = 28'(cv);
      end
      roch_pkg::OP_LOX_B: begin
        mul_a = 28'(rely);
        mul_b = 28'(sv);
      end
      roch_pkg::OP_LOY_A: begin
        mul_a = 28'(relx);
        mul_b = 28'(sv);
      end
      roch_pkg::OP_LOY_B: begin
        mul_a = 28'(rely);
        mul_b = 28'(cv);
      end
      roch_pkg::OP_LDX_A: begin
        mul_a = 28'(nx_r);
        mul_b = 28'(cv);
      end
      roch_pkg::OP_LDX_B: begin
        mul_a = 28'(ny_r);
        mul_b = 28'(sv);
      end
      roch_pkg::OP_LDY_A: begin
        mul_a = 28'(nx_r);
        mul_b = 28'(sv);
      end
      roch_pkg::OP_LDY_B: begin
        mul_a = 28'(ny_r);
        mul_b = 28'(cv);
      end
      roch_pkg::OP_HX: begin
        mul_a = 28'(nx_r);
        mul_b = 28'({1'b0, best_t_r});
      end
      roch_pkg::OP_HY: begin
        mul_a = 28'(ny_r);
        mul_b = 28'({1'b0, best_t_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    sqrt_req.start = (state_r == roch_pkg::ST_LEN) && (len2_r != '0);
    sqrt_req.value = {len2_r, 16'd0};

    div_req.start    = 1'b0;
    div_req.dividend = numabs;
    div_req.divisor  = dabs;
    case (state_r)
      roch_pkg::ST_SQRT: begin
        div_req.start    = sqrt_done;
        div_req.dividend = 64'({ax, 22'd0});
        div_req.divisor  = root;
      end
      roch_pkg::ST_DIVX: begin
        div_req.start    = div_done;
        div_req.dividend = 64'({ay, 22'd0});
        div_req.divisor  = l_r;
      end
      roch_pkg::ST_SLAB: div_req.start = !par;
      roch_pkg::ST_SL1:  div_req.start = div_done;
      default:           div_req.start = 1'b0;
    endcase
  end

  // Datapath and query state
  always_comb begin
    op_nxt       = op_r;
    half_nxt     = half_r;
    axis_nxt     = axis_r;
    mask_nxt     = mask_r;
    rlen_nxt     = rlen_r;
    best_t_nxt   = best_t_r;
    best_idx_nxt = best_idx_r;
    found_nxt    = found_r;
    cnt_nxt      = cnt_r;
    rx_nxt = rx_r; ry_nxt = ry_r; dx_nxt = dx_r; dy_nxt = dy_r;
    bx_nxt = bx_r; by_nxt = by_r; w_nxt = w_r; h_nxt = h_r;
    ang_nxt  = ang_r;
    last_nxt = last_r;
    cand_nxt = cand_r;
    idx_nxt  = idx_r;
    len2_nxt = len2_r;
    l_nxt    = l_r;
    nx_nxt = nx_r; ny_nxt = ny_r;
    u2_nxt = u2_r; t1_nxt = t1_r; tp_nxt = tp_r; sf_nxt = sf_r; cf_nxt = cf_r;
    acc_nxt = acc_r; lox_nxt = lox_r; loy_nxt = loy_r; ldx_nxt = ldx_r; ldy_nxt = ldy_r;
    tmin_nxt = tmin_r; tmax_nxt = tmax_r; tq_nxt = tq_r;
    nsign_nxt = nsign_r;
    px_nxt = px_r; py_nxt = py_r;
    out_hit_nxt  = out_hit_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_we) begin
      case (cfg_addr)
        roch_pkg::REG_MASK: mask_nxt = cfg_wdata[3:0];
        roch_pkg::REG_LEN:  rlen_nxt = cfg_wdata;
        default:            mask_nxt = mask_r;
      endcase
    end

    case (state_r)
      roch_pkg::ST_IDLE: begin
        if (accept) begin
          rx_nxt  = $signed(in_tdata[23:0]);
          ry_nxt  = $signed(in_tdata[47:24]);
          dx_nxt  = $signed(in_tdata[71:48]);
          dy_nxt  = $signed(in_tdata[95:72]);
          bx_nxt  = $signed(in_tdata[119:96]);
          by_nxt  = $signed(in_tdata[143:120]);
          w_nxt   = in_tdata[166:144];
          h_nxt   = in_tdata[189:167];
          ang_nxt = in_tdata[205:190];
          last_nxt = in_tlast;
          cand_nxt = in_cand;
          idx_nxt  = cnt_ext[7:0];
          if (cnt_r == '0) best_t_nxt = rlen_r;
          if (cnt_r < CW'(MAX_BOXES)) cnt_nxt = cnt_r + CW'(1);
          op_nxt   = roch_pkg::OP_AX2;
          half_nxt = 1'b0;
        end
      end
      roch_pkg::ST_MUL: begin
        half_nxt = !half_r;
        if (half_r) begin
          op_nxt = roch_pkg::op_t'(op_r + 5'd1);
          case (op_r)
            roch_pkg::OP_AX2:  len2_nxt = prod[47:0];
            roch_pkg::OP_AY2:  len2_nxt = len2_r + prod[47:0];
            roch_pkg::OP_SF_U2, roch_pkg::OP_CF_U2: u2_nxt = pr[14:0];
            roch_pkg::OP_SF_T1, roch_pkg::OP_CF_T1: t1_nxt = roch_pkg::SIN_B - pr[13:0];
            roch_pkg::OP_SF_T, roch_pkg::OP_CF_T:   tp_nxt = roch_pkg::SIN_A - pr[14:0];
            roch_pkg::OP_SF_R:  sf_nxt = pr[15:0];
            roch_pkg::OP_CF_R:  cf_nxt = pr[15:0];
            roch_pkg::OP_LOX_A: acc_nxt = 48'(prod);
            roch_pkg::OP_LOX_B: lox_nxt = acc_r + 48'(prod);
            roch_pkg::OP_LOY_A: acc_nxt = -48'(prod);
            roch_pkg::OP_LOY_B: loy_nxt = acc_r + 48'(prod);
            roch_pkg::OP_LDX_A: acc_nxt = 48'(prod);
            roch_pkg::OP_LDX_B: ldx_nxt = 32'(acc_r + 48'(prod));
            roch_pkg::OP_LDY_A: acc_nxt = -48'(prod);
            roch_pkg::OP_LDY_B: begin
              ldy_nxt  = 32'(acc_r + 48'(prod));
              axis_nxt = 1'b0;
              tmin_nxt = '0;
              tmax_nxt = 64'(rlen_r);
            end
            roch_pkg::OP_HX: px_nxt = hit_coord(rx_r, prod);
            roch_pkg::OP_HY: py_nxt = hit_coord(ry_r, prod);
            default: acc_nxt = acc_r;
          endcase
        end
      end
      roch_pkg::ST_LEN: begin
        // zero direction: no test, hit point sits on the origin
        if (len2_r == '0) begin
          nx_nxt   = '0;
          ny_nxt   = '0;
          cand_nxt = 1'b0;
        end
      end
      roch_pkg::ST_SQRT: begin
        if (sqrt_done) l_nxt = root;
      end
      roch_pkg::ST_DIVX: begin
        if (div_done) nx_nxt = dx_r[23] ? -$signed(mcap) : $signed(mcap);
      end
      roch_pkg::ST_DIVY: begin
        if (div_done) begin
          ny_nxt   = dy_r[23] ? -$signed(mcap) : $signed(mcap);
          op_nxt   = roch_pkg::OP_SF_U2;
          half_nxt = 1'b0;
        end
      end
      roch_pkg::ST_SLAB: begin
        if (par) begin
          if (inr) axis_nxt = 1'b1;
        end else begin
          nsign_nxt = num[63] ^ d[31];
        end
      end
      roch_pkg::ST_SL1: begin
        if (div_done) begin
          tq_nxt    = qs;
          nsign_nxt = num[63] ^ d[31];
        end
      end
      roch_pkg::ST_SL2: begin
        if (div_done) begin
          tmin_nxt = tmin_c;
          tmax_nxt = tmax_c;
          axis_nxt = 1'b1;
        end
      end
      roch_pkg::ST_UPD: begin
        if ((tmin_r <= 64'(rlen_r)) && (tmin_r < 64'(best_t_r))) begin
          best_t_nxt   = tmin_r[15:0];
          best_idx_nxt = idx_r;
          found_nxt    = 1'b1;
        end
      end
      roch_pkg::ST_FIN: begin
        op_nxt   = roch_pkg::OP_HX;
        half_nxt = 1'b0;
      end
      roch_pkg::ST_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = found_r;
          out_data_nxt  = found_r ? {py_r, px_r, best_t_r, best_idx_r} : '0;
          best_t_nxt    = rlen_r;
          best_idx_nxt  = '0;
          found_nxt     = 1'b0;
          cnt_nxt       = '0;
        end
      end
      default: half_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= roch_pkg::ST_IDLE;
      op_r        <= roch_pkg::OP_AX2;
      half_r      <= 1'b0;
      axis_r      <= 1'b0;
      mask_r      <= '0;
      rlen_r      <= roch_pkg::LEN_RST;
      best_t_r    <= roch_pkg::LEN_RST;
      best_idx_r  <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      cand_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      half_r      <= half_nxt;
      axis_r      <= axis_nxt;
      mask_r      <= mask_nxt;
      rlen_r      <= rlen_nxt;
      best_t_r    <= best_t_nxt;
      best_idx_r  <= best_idx_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      cand_r      <= cand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rx_r <= rx_nxt; ry_r <= ry_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; w_r <= w_nxt; h_r <= h_nxt;
    ang_r <= ang_nxt;
    idx_r <= idx_nxt;
    len2_r <= len2_nxt;
    l_r <= l_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt;
    u2_r <= u2_nxt; t1_r <= t1_nxt; tp_r <= tp_nxt; sf_r <= sf_nxt; cf_r <= cf_nxt;
    acc_r <= acc_nxt; lox_r <= lox_nxt; loy_r <= loy_nxt; ldx_r <= ldx_nxt; ldy_r <= ldy_nxt;
    tmin_r <= tmin_nxt; tmax_r <= tmax_nxt; tq_r <= tq_nxt;
    nsign_r <= nsign_nxt;
    px_r <= px_nxt; py_r <= py_nxt;
    out_hit_r  <= out_hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_hit_r;

  a_one_box : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("box accepted while another is in work");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("miss result carries non-zero fields");

  a_count_sat : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BOXES))
    else $error("box count beyond saturation");

  a_found_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == roch_pkg::ST_UPD && found_nxt && !found_r) |=> (best_t_r <= rlen_r))
    else $error("hit distance beyond segment");

endmodule
